[hw/rtl/elpq_pkg.sv]
// Shared types and constants for the expiry lot priority queue.
package elpq_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_TAKE   = 2'd2;

  localparam int unsigned SUM_W = 39;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic [31:0] expiry;
    logic [31:0] quantity;
  } lot_t;

endpackage

[hw/rtl/expiry_lot_priority_queue_top.sv]
// Top level of the expiry lot priority queue: a binary min-heap of stock lots.
// Insert: the new lot is written at the end of the heap and sifted up one parent per level.
// Check and take: expired lots are popped from the root first, each pop sifting the last lot down
// (take pops further lots; a split lot is put back like an insert).
// One word in flight; the next word is accepted the cycle after the result is taken.
// Reset clears the lot count, the sum and the sequencer; lot memory is not cleared.
module expiry_lot_priority_queue_top import elpq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  // expiry[31:0], quantity[63:32], now[95:64]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ok[0], overflow[1], available_total[40:2], lot_count[48:41], zero fill
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned SW = (SUM_W + 1 > 32 + CW) ? SUM_W + 1 : 32 + CW;
  localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_UPRD   = 5'd1;
  localparam logic [4:0] S_UPWT   = 5'd2;
  localparam logic [4:0] S_UPCMP  = 5'd3;
  localparam logic [4:0] S_PURGE  = 5'd4;
  localparam logic [4:0] S_PRWT   = 5'd5;
  localparam logic [4:0] S_PRCHK  = 5'd6;
  localparam logic [4:0] S_POPLR  = 5'd7;
  localparam logic [4:0] S_POPLW  = 5'd8;
  localparam logic [4:0] S_POPLG  = 5'd9;
  localparam logic [4:0] S_DNL    = 5'd10;
  localparam logic [4:0] S_DNLW   = 5'd11;
  localparam logic [4:0] S_DNR    = 5'd12;
  localparam logic [4:0] S_DNRW   = 5'd13;
  localparam logic [4:0] S_DNDEC  = 5'd14;
  localparam logic [4:0] S_TAKE   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;
  localparam logic [4:0] S_DNSW   = 5'd18;

  logic [4:0]      state_q, state_d;
  logic [1:0]      op_q;
  logic [31:0]     need_q;
  logic [31:0]     now_q;
  logic [CW-1:0]   total_q;
  logic [SW-1:0]   sum_q;
  logic [31:0]     taken_q;
  logic            ok_q, ovf_q;
  logic            splitting_q;
  logic [CW-1:0]   pos_q;
  logic [CW-1:0]   best_q;
  lot_t            cur_q;
  lot_t            best_lot_q;
  lot_t            rd_q;
  lot_t            popped_q;

  lot_t            mem [HEAP_DEPTH];
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  lot_t            wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  logic [CW-1:0] parent, lchild, rchild;
  logic [CW:0]   lch_w, rch_w;
  logic          lch_in, rch_in;
  assign parent = (pos_q - CW'(1)) >> 1;
  assign lch_w  = {pos_q, 1'b1};
  assign rch_w  = {pos_q, 1'b0} + (CW+1)'(2);
  assign lchild = lch_w[CW-1:0];
  assign rchild = rch_w[CW-1:0];
  assign lch_in = lch_w < {1'b0, total_q};
  assign rch_in = rch_w < {1'b0, total_q};

  logic [32:0] remain;
  assign remain = {1'b0, need_q} - {1'b0, taken_q};

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);

  logic [SUM_W-1:0] sum_sat;
  assign sum_sat = (sum_q > SW'(SUM_MAX)) ? SUM_MAX : sum_q[SUM_W-1:0];
  logic [7:0] cnt8;
  assign cnt8 = 8'(total_q);
  assign m_axis_tdata = {7'd0, cnt8, sum_sat, ovf_q, ok_q};

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = cur_q;
    raddr = '0;
    case (state_q)
      S_IDLE: begin
        waddr = total_q[AW-1:0];
        wdata = '{expiry: s_axis_tdata[31:0], quantity: s_axis_tdata[63:32]};
        we = s_axis_tvalid && s_axis_tready &&
             s_axis_tuser == OP_INSERT && total_q < DEPTH_C;
      end
      S_UPRD, S_UPWT: raddr = parent[AW-1:0];
      S_UPCMP: begin
        if (pos_q != '0 && rd_q.expiry > cur_q.expiry) begin
          we = 1'b1; waddr = pos_q[AW-1:0]; wdata = rd_q;
        end
      end
      S_PURGE: raddr = '0;
      S_POPLR, S_POPLW: raddr = total_q[AW-1:0];
      S_DNL:   raddr = lchild[AW-1:0];
      S_DNR:   raddr = rchild[AW-1:0];
      S_DNSW: begin
        we = 1'b1; waddr = pos_q[AW-1:0]; wdata = best_lot_q;
      end
      S_DNDEC: begin
        we = 1'b1; waddr = pos_q[AW-1:0]; wdata = cur_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      sum_q   <= '0;
      ok_q    <= 1'b0;
      ovf_q   <= 1'b0;
      splitting_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= s_axis_tuser;
            need_q  <= s_axis_tdata[63:32];
            now_q   <= s_axis_tdata[95:64];
            taken_q <= '0;
            ok_q    <= 1'b0;
            ovf_q   <= 1'b0;
            splitting_q <= 1'b0;
            cur_q   <= '{expiry: s_axis_tdata[31:0], quantity: s_axis_tdata[63:32]};
            pos_q   <= total_q;
            if (s_axis_tuser == OP_INSERT) begin
              if (total_q < DEPTH_C) begin
                total_q <= total_q + CW'(1);
                sum_q   <= sum_q + SW'(s_axis_tdata[63:32]);
                ok_q    <= 1'b1;
              end else begin
                ovf_q <= 1'b1;
              end
            end
          end
        end
        S_UPCMP: begin
          if (pos_q != '0 && rd_q.expiry > cur_q.expiry) begin
            pos_q <= parent;
          end
        end
        S_PRCHK, S_TAKE: begin
          popped_q <= rd_q;
          if (state_d == S_POPLR) begin
            sum_q   <= sum_q - SW'(rd_q.quantity);
            total_q <= total_q - CW'(1);
            if (state_q == S_TAKE) begin
              if ({1'b0, rd_q.quantity} <= remain) begin
                taken_q <= taken_q + rd_q.quantity;
              end else begin
                splitting_q <= 1'b1;
              end
            end
          end
        end
        S_POPLG: begin
          cur_q  <= rd_q;
          best_q <= '0;
          pos_q  <= '0;
          best_lot_q <= rd_q;
        end
        S_DNLW: begin
          if (lch_in && rd_q.expiry < cur_q.expiry) begin
            best_q <= lchild;
            best_lot_q <= rd_q;
          end else begin
            best_q <= pos_q;
            best_lot_q <= cur_q;
          end
        end
        S_DNRW: begin
          if (rch_in && rd_q.expiry < best_lot_q.expiry) begin
            best_q <= rchild;
            best_lot_q <= rd_q;
          end
        end
        S_DNSW: begin
          pos_q <= best_q;
        end
        S_DNDEC: begin
          if (splitting_q) begin
            splitting_q <= 1'b0;
            taken_q <= need_q;
            cur_q <= '{expiry: popped_q.expiry,
                       quantity: popped_q.quantity - remain[31:0]};
            pos_q   <= total_q;
            total_q <= total_q + CW'(1);
            sum_q   <= sum_q + SW'(popped_q.quantity - remain[31:0]);
          end
        end
        S_DONE: begin
          if (op_q == OP_CHECK) begin
            ok_q <= (sum_q >= SW'(need_q));
          end else if (op_q == OP_TAKE) begin
            ok_q <= (taken_q >= need_q);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == OP_INSERT) begin
            state_d = (total_q < DEPTH_C) ? S_UPRD : S_OUT;
          end else if (s_axis_tuser == OP_CHECK || s_axis_tuser == OP_TAKE) begin
            state_d = S_PURGE;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_UPRD:  state_d = S_UPWT;
      S_UPWT:  state_d = S_UPCMP;
      S_UPCMP: begin
        if (pos_q != '0 && rd_q.expiry > cur_q.expiry) begin
          state_d = S_UPRD;
        end else begin
          state_d = S_DNDEC;
        end
      end
      S_PURGE: state_d = S_PRWT;
      S_PRWT:  state_d = S_PRCHK;
      S_PRCHK: begin
        if (total_q != '0 && rd_q.expiry <= now_q) begin
          state_d = S_POPLR;
        end else if (op_q == OP_TAKE && total_q != '0 && taken_q < need_q) begin
          state_d = S_TAKE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_TAKE:  state_d = S_POPLR;
      S_POPLR: state_d = S_POPLW;
      S_POPLW: state_d = S_POPLG;
      S_POPLG: state_d = (total_q == '0) ? S_DNDEC : S_DNL;
      S_DNL:   state_d = S_DNLW;
      S_DNLW:  state_d = S_DNR;
      S_DNR:   state_d = S_DNRW;
      S_DNRW:  state_d = S_DNSW;
      S_DNSW:  state_d = (best_q == pos_q) ? S_DNDEC : S_DNL;
      S_DNDEC: begin
        if (splitting_q) begin
          state_d = S_UPRD;
        end else if (op_q == OP_INSERT) begin
          state_d = S_OUT;
        end else begin
          state_d = S_PURGE;
        end
      end
      S_DONE:  state_d = S_OUT;
      S_OUT:   state_d = m_axis_tready ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[tb/sv/elpq_checker.sv]
// Checker for the expiry lot priority queue: predicts results and compares them.
module elpq_checker import elpq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,
  input  logic [95:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [55:0]  m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o,
  output int           lots_held_o,
  output int           results_seen_o
);

  typedef struct packed {
    logic [7:0]  lot_count;
    logic [38:0] available_total;
    logic        overflow;
    logic        ok;
  } lot_result_t;

  lot_t        heap_lots[HEAP_DEPTH];
  int unsigned heap_size;
  logic [63:0] stock_sum;
  lot_result_t result_queue[$];

  function automatic void swap_lots(int unsigned a, int unsigned b);
    lot_t t;
    t = heap_lots[a];
    heap_lots[a] = heap_lots[b];
    heap_lots[b] = t;
  endfunction

  function automatic bit push_lot(logic [31:0] e, logic [31:0] q);
    int unsigned pos;
    int unsigned up;
    if (heap_size >= HEAP_DEPTH) return 1'b0;
    pos = heap_size;
    heap_size++;
    heap_lots[pos].expiry = e;
    heap_lots[pos].quantity = q;
    stock_sum += q;
    while (pos != 0) begin
      up = (pos - 1) / 2;
      if (!(heap_lots[up].expiry > heap_lots[pos].expiry)) break;
      swap_lots(pos, up);
      pos = up;
    end
    return 1'b1;
  endfunction

  function automatic lot_t pop_lot();
    lot_t top;
    int unsigned pos;
    int unsigned best;
    int unsigned l;
    top = heap_lots[0];
    stock_sum -= top.quantity;
    heap_size--;
    if (heap_size > 0) begin
      heap_lots[0] = heap_lots[heap_size];
      pos = 0;
      forever begin
        best = pos;
        l = 2 * pos + 1;
        if (l < heap_size && heap_lots[l].expiry < heap_lots[best].expiry) best = l;
        if (l + 1 < heap_size && heap_lots[l + 1].expiry < heap_lots[best].expiry)
          best = l + 1;
        if (best == pos) break;
        swap_lots(pos, best);
        pos = best;
      end
    end
    return top;
  endfunction

  function automatic lot_result_t apply_word(logic [1:0] op, logic [95:0] w);
    lot_result_t r;
    logic [31:0] e;
    logic [31:0] q;
    logic [31:0] now;
    logic [63:0] taken;
    lot_t        lot;
    e = w[31:0];
    q = w[63:32];
    now = w[95:64];
    r = '0;
    if (op == OP_INSERT) begin
      if (push_lot(e, q)) r.ok = 1'b1;
      else r.overflow = 1'b1;
    end else if (op == OP_CHECK || op == OP_TAKE) begin
      while (heap_size > 0 && heap_lots[0].expiry <= now) lot = pop_lot();
      if (op == OP_CHECK) begin
        r.ok = stock_sum >= q;
      end else begin
        taken = 0;
        while (heap_size > 0 && taken < q) begin
          lot = pop_lot();
          if (taken + lot.quantity <= q) begin
            taken += lot.quantity;
          end else begin
            void'(push_lot(lot.expiry, lot.quantity - 32'(q - taken)));
            taken = q;
          end
        end
        r.ok = taken >= q;
      end
    end
    r.available_total = (stock_sum > SUM_MAX) ? SUM_MAX : stock_sum[38:0];
    r.lot_count = heap_size[7:0];
    return r;
  endfunction

  assign pending_o = result_queue.size();
  assign lots_held_o = heap_size;

  always @(posedge clk_i or negedge rst_ni) begin
    lot_result_t want;
    lot_result_t got;
    if (!rst_ni) begin
      heap_size = 0;
      stock_sum = 0;
      result_queue.delete();
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[48:0];
        results_seen_o <= results_seen_o + 1;
        if (result_queue.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = result_queue.pop_front();
          if (got !== want || m_axis_tdata[55:49] !== '0) begin
            if (fail_count_o < 10)
              $display({"mismatch: exp ok=%0d ovf=%0d tot=%0d cnt=%0d,",
                        " got ok=%0d ovf=%0d tot=%0d cnt=%0d"},
                       want.ok, want.overflow, want.available_total, want.lot_count,
                       got.ok, got.overflow, got.available_total, got.lot_count);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        result_queue.push_back(apply_word(s_axis_tuser, s_axis_tdata));
    end
  end

endmodule

[tb/sv/tb.sv]
// Testbench top: drives stimulus into the lot queue and reports the verdict.
module tb;
  import elpq_pkg::*;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned LIMIT = 3000000;
  localparam logic [1:0]  OP_UNUSED = 2'd3;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser = '0;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;
  int           fail_count;
  int           pending;
  int           lots_held;
  int           results_seen;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_off = 1'b0;
  int unsigned  cycles = 0;
  int           words_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  expiry_lot_priority_queue_top #(.HEAP_DEPTH(DEPTH)) u_top (.*);

  elpq_checker #(.HEAP_DEPTH(DEPTH)) u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .lots_held_o(lots_held),
    .results_seen_o(results_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(logic [1:0] op, logic [31:0] e, logic [31:0] q,
                           logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {now, q, e};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return 32'hFFFF_FFFF - $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [31:0] now_time;
    logic [1:0]  op;
    now_time = $urandom_range(1000);
    for (int i = 0; i < n; i++) begin
      now_time += $urandom_range(20);
      case ($urandom_range(9))
        0: send_word(OP_UNUSED, $urandom, $urandom, $urandom);
        1: send_word(2'($urandom_range(2)), rand_val(), rand_val(), rand_val());
        2, 3, 4, 5: send_word(OP_INSERT, now_time + $urandom_range(300),
                              $urandom_range(1000), $urandom);
        6: send_word(OP_CHECK, $urandom, $urandom_range(20000), now_time);
        default: begin
          op = OP_TAKE;
          send_word(op, $urandom, $urandom_range(3000), now_time);
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 13;
    recv_idle_pct = 86;
    send_word(OP_CHECK, 0, 0, 0);
    send_word(OP_TAKE, 0, 5, 0);
    send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(OP_INSERT, 10, 0, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 10, 7, 0);
    send_word(OP_INSERT, 5, 3, 0);
    send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_CHECK, 0, 32'hFFFF_FFFF, 4);
    send_word(OP_TAKE, 0, 0, 4);
    send_word(OP_TAKE, 0, 5, 5);
    send_word(OP_CHECK, 0, 32'hFFFF_FFFF, 0);
    send_word(OP_TAKE, 0, 32'hFFFF_FFFF, 9);
    send_word(OP_TAKE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_word(OP_TAKE, 0, 1, 0);
    drain();
    // fill past capacity, with the receiver holding off at the start
    hold_off = 1'b1;
    fork
      for (int i = 0; i < DEPTH + 4; i++) send_word(OP_INSERT, $urandom, $urandom, 0);
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();
    send_word(OP_CHECK, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_word(OP_TAKE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(350);
    drain();
    send_idle_pct = 86;
    recv_idle_pct = 13;
    random_phase(300);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(350);
    drain();
    repeat (2000) @(posedge clk_i);
    $display("Sent %0d words, checked %0d results, including a full-heap overflow run.",
             words_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/elpq_pkg.sv
hw/rtl/expiry_lot_priority_queue_top.sv
tb/sv/elpq_checker.sv
tb/sv/tb.sv
